/* rtl/chacha20_stream_cipher_macros.svh */
// Assertion helpers for the cipher block.
`ifndef CHACHA20_STREAM_CIPHER_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_MACROS_SVH
`define CC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("%m: check failed");
`define CC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("%m: check failed");
`endif

/* rtl/cc20_pkg.sv */
`default_nettype none
package cc20_pkg;
	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_NONCE_LO = 3'd4;
	localparam logic [2:0] REG_NONCE_HI = 3'd5;
	localparam logic [2:0] REG_INIT_CTR = 3'd6;

	typedef logic [31:0] word_t;
	typedef word_t [15:0] block_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} quad_t;

	function automatic word_t rotl(input word_t x, input int unsigned n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction
endpackage
`default_nettype wire

/* rtl/cc20_stream_if.sv */
`default_nettype none
interface cc20_stream_if;
	logic        valid;
	logic        ready;
	logic [63:0] data;
	logic [3:0]  count;
	logic        last;
	modport source (output valid, output data, output count, output last, input ready);
	modport sink (input valid, input data, input count, input last, output ready);
endinterface
`default_nettype wire

/* rtl/cc20_quarter.sv */
`default_nettype none
// One quarter round lane, cut in two half steps to bound the adder chain.
module cc20_quarter
	import cc20_pkg::*;
(
	input  wire quad_t in,
	input  wire logic  second_half,
	output quad_t      out
);
	word_t a1, b1, c1, d1;
	int unsigned rd, rb;
	always_comb begin
		rd = second_half ? 8 : 16;
		rb = second_half ? 7 : 12;
		a1 = in.a + in.b;
		d1 = rotl(in.d ^ a1, rd);
		c1 = in.c + d1;
		b1 = rotl(in.b ^ c1, rb);
		out = '{a: a1, b: b1, c: c1, d: d1};
	end
endmodule
`default_nettype wire

/* rtl/cc20_core.sv */
`default_nettype none
// Block function: four quarter round lanes, two half steps per round,
// then a merge stage that adds the input state back.
module cc20_core
	import cc20_pkg::*;
#(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire block_t init,
	output logic        done,
	output block_t      result
);
	localparam int STEPS = DOUBLE_ROUNDS * 4;
	localparam int SW = $clog2(STEPS + 1);

	block_t w_q, init_q, nx;
	logic [SW-1:0] step_q;
	logic busy_q;
	quad_t qi [4];
	quad_t qo [4];
	logic diag, half;

	assign half = step_q[0];
	assign diag = step_q[1];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			if (!diag) begin
				qi[l] = '{w_q[l], w_q[4+l], w_q[8+l], w_q[12+l]};
			end else begin
				qi[l] = '{w_q[l], w_q[4+((l+1)%4)], w_q[8+((l+2)%4)], w_q[12+((l+3)%4)]};
			end
		end
		nx = w_q;
		for (int l = 0; l < 4; l++) begin
			if (!diag) begin
				nx[l] = qo[l].a; nx[4+l] = qo[l].b; nx[8+l] = qo[l].c; nx[12+l] = qo[l].d;
			end else begin
				nx[l] = qo[l].a;
				nx[4+((l+1)%4)] = qo[l].b;
				nx[8+((l+2)%4)] = qo[l].c;
				nx[12+((l+3)%4)] = qo[l].d;
			end
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		cc20_quarter u_q (.in(qi[g]), .second_half(half), .out(qo[g]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == SW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			w_q <= init;
			init_q <= init;
		end else if (busy_q) begin
			w_q <= nx;
		end
	end

	// merge: add input state to the permuted words
	always_ff @(posedge clk) begin
		if (busy_q && step_q == SW'(STEPS - 1)) begin
			for (int i = 0; i < 16; i++) result[i] <= nx[i] + init_q[i];
		end
	end
endmodule
`default_nettype wire

/* rtl/chacha20_stream_cipher.sv */
`default_nettype none
// ChaCha20 (RFC 8439) encrypt/decrypt on 8-byte items, little-endian. A 64-byte
// keystream block is computed on the first item of a message and every eighth
// item after; for that item the four-lane quarter round unit does half a round
// each cycle, and then the result is XORed and offered on the output. Other
// items skip the block computation. One item is handled at a time: the next
// request is taken in the cycle after the result is accepted, so output stalls
// hold it back. Registers lie at byte address 8*i; write config only while idle.
module chacha20_stream_cipher
	import cc20_pkg::*;
#(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  psel,
	input  wire logic  penable,
	input  wire logic  pwrite,
	input  wire logic [5:0] paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic       pready,
	cc20_stream_if.sink   in_s,
	cc20_stream_if.source out_s
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_GEN  = 4'b0010,
		ST_XOR  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [63:0] key0_q, key1_q, key2_q, key3_q, nlo_q;
	logic [31:0] nhi_q, ictr_q, ctr_q;
	logic [2:0] pos_q;
	logic start_q;
	logic [63:0] d_q;
	logic [3:0] cnt_q;
	logic last_q;
	block_t ks_q, init, res;
	logic core_start, core_done;
	logic [2:0] ridx;
	logic [31:0] ctr_use;

	assign pready = 1'b1;
	assign ridx = paddr[5:3];

	always_comb begin
		case (ridx)
			REG_KEY0: prdata = key0_q;
			REG_KEY1: prdata = key1_q;
			REG_KEY2: prdata = key2_q;
			REG_KEY3: prdata = key3_q;
			REG_NONCE_LO: prdata = nlo_q;
			REG_NONCE_HI: prdata = {32'd0, nhi_q};
			REG_INIT_CTR: prdata = {32'd0, ictr_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0;
			nlo_q <= '0; nhi_q <= '0; ictr_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_KEY0: key0_q <= pwdata;
				REG_KEY1: key1_q <= pwdata;
				REG_KEY2: key2_q <= pwdata;
				REG_KEY3: key3_q <= pwdata;
				REG_NONCE_LO: nlo_q <= pwdata;
				REG_NONCE_HI: nhi_q <= pwdata[31:0];
				REG_INIT_CTR: ictr_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	assign ctr_use = start_q ? ictr_q : ctr_q;
	assign init = {nhi_q, nlo_q[63:32], nlo_q[31:0], ctr_use,
		key3_q[63:32], key3_q[31:0], key2_q[63:32], key2_q[31:0],
		key1_q[63:32], key1_q[31:0], key0_q[63:32], key0_q[31:0],
		SIGMA3, SIGMA2, SIGMA1, SIGMA0};

	assign in_s.ready = (state_q == ST_IDLE);
	assign core_start = in_s.valid && in_s.ready && (start_q || pos_q == 3'd0);

	cc20_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
		.clk(clk), .arst_n(arst_n), .start(core_start), .init(init),
		.done(core_done), .result(res)
	);

	logic [63:0] ks, mask;
	logic [3:0] used;
	always_comb begin
		ks = {ks_q[{pos_q, 1'b1}], ks_q[{pos_q, 1'b0}]};
		used = (cnt_q > 4'd8) ? 4'd8 : cnt_q;
		for (int b = 0; b < 8; b++) mask[8*b +: 8] = (4'(b) < used) ? 8'hff : 8'h00;
	end

	assign out_s.valid = (state_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctr_q <= '0;
			pos_q <= '0;
			start_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: if (in_s.valid) begin
					if (start_q) begin
						ctr_q <= ictr_q;
						pos_q <= '0;
					end
					state_q <= core_start ? ST_GEN : ST_XOR;
				end
				ST_GEN: if (core_done) state_q <= ST_XOR;
				ST_XOR: state_q <= ST_OUT;
				ST_OUT: if (out_s.ready) begin
					state_q <= ST_IDLE;
					if (pos_q == 3'd7) ctr_q <= ctr_q + 32'd1;
					if (last_q) begin
						start_q <= 1'b1;
						pos_q <= '0;
					end else begin
						start_q <= 1'b0;
						pos_q <= pos_q + 3'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_s.valid && in_s.ready) begin
			d_q <= in_s.data;
			cnt_q <= in_s.count;
			last_q <= in_s.last;
		end
		if (core_done) ks_q <= res;
		if (state_q == ST_XOR) begin
			out_s.data <= (d_q ^ ks) & mask;
			out_s.count <= cnt_q;
			out_s.last <= last_q;
		end
	end
endmodule
`default_nettype wire

/* rtl/cc20_checker.sv */
`default_nettype none
`include "chacha20_stream_cipher_macros.svh"
module cc20_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic pready
);
	`CC_ASSERT_IMPL(a_pready, clk, arst_n, 1'b1, pready)
	`CC_ASSERT_IMPL(a_no_in_while_out, clk, arst_n, out_valid, !in_ready)
	`CC_ASSERT_NEXT(a_out_after_take, clk, arst_n, out_valid && out_ready, !out_valid)
	`CC_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule

bind chacha20_stream_cipher cc20_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_s.valid), .in_ready(in_s.ready),
	.out_valid(out_s.valid), .out_ready(out_s.ready), .pready(pready)
);
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import cc20_pkg::*;

	localparam int ROUNDS2 = 10;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	cc20_stream_if in_if();
	cc20_stream_if out_if();

	chacha20_stream_cipher #(.DOUBLE_ROUNDS(ROUNDS2)) i_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_s(in_if.sink), .out_s(out_if.source)
	);

	always #5 clk = ~clk;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0] count;
		logic last;
	} cipher_item_t;

	// shadow of the cipher state
	logic [63:0] key_q[4];
	logic [63:0] nonce_lo_q;
	logic [31:0] nonce_hi_q;
	logic [31:0] ctr_init_q;
	word_t ks_q[16];
	logic [31:0] blk_ctr;
	logic [2:0] word_pos;
	logic msg_first;

	cipher_item_t expected_q[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	int messages = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;

	initial begin
		in_if.valid = 1'b0;
		in_if.data = '0;
		in_if.count = '0;
		in_if.last = 1'b0;
		out_if.ready = 1'b0;
		foreach (key_q[i]) key_q[i] = '0;
		nonce_lo_q = '0;
		nonce_hi_q = '0;
		ctr_init_q = '0;
		blk_ctr = '0;
		word_pos = '0;
		msg_first = 1'b1;
	end

	function automatic word_t rot_left(word_t x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void qround(ref word_t w[16], input int a, int b, int c, int d);
		w[a] += w[b]; w[d] = rot_left(w[d] ^ w[a], 16);
		w[c] += w[d]; w[b] = rot_left(w[b] ^ w[c], 12);
		w[a] += w[b]; w[d] = rot_left(w[d] ^ w[a], 8);
		w[c] += w[d]; w[b] = rot_left(w[b] ^ w[c], 7);
	endfunction

	function automatic void build_keystream();
		word_t init_w[16];
		word_t w[16];
		init_w[0] = SIGMA0; init_w[1] = SIGMA1; init_w[2] = SIGMA2; init_w[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init_w[4 + 2 * i] = key_q[i][31:0];
			init_w[5 + 2 * i] = key_q[i][63:32];
		end
		init_w[12] = blk_ctr;
		init_w[13] = nonce_lo_q[31:0];
		init_w[14] = nonce_lo_q[63:32];
		init_w[15] = nonce_hi_q;
		w = init_w;
		for (int r = 0; r < ROUNDS2; r++) begin
			qround(w, 0, 4, 8, 12); qround(w, 1, 5, 9, 13);
			qround(w, 2, 6, 10, 14); qround(w, 3, 7, 11, 15);
			qround(w, 0, 5, 10, 15); qround(w, 1, 6, 11, 12);
			qround(w, 2, 7, 8, 13); qround(w, 3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++) ks_q[i] = w[i] + init_w[i];
	endfunction

	function automatic cipher_item_t encrypt_item(cipher_item_t req);
		cipher_item_t res;
		logic [63:0] ks, mask;
		int used;
		if (msg_first) begin
			blk_ctr = ctr_init_q;
			word_pos = '0;
			build_keystream();
		end else if (word_pos == 0) begin
			build_keystream();
		end
		ks = {ks_q[2 * word_pos + 1], ks_q[2 * word_pos]};
		used = (req.count > 8) ? 8 : req.count;
		mask = (used == 8) ? '1 : ((64'd1 << (8 * used)) - 64'd1);
		res.data = (req.data ^ ks) & mask;
		res.count = req.count;
		res.last = req.last;
		word_pos = word_pos + 3'd1;
		if (word_pos == 0) blk_ctr = blk_ctr + 32'd1;
		if (req.last) begin
			msg_first = 1'b1;
			word_pos = '0;
		end else begin
			msg_first = 1'b0;
		end
		return res;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, received);
	endtask

	// drop valid for the length of a gap
	task automatic idle_burst();
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic send_item(logic [63:0] data, logic [3:0] count, logic last);
		cipher_item_t req;
		idle_burst();
		req = '{data: data, count: count, last: last};
		in_if.valid <= 1'b1;
		in_if.data <= data;
		in_if.count <= count;
		in_if.last <= last;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		expected_q.push_back(encrypt_item(req));
		sent++;
		if (last) messages++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] value);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 3'b000}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_KEY0: key_q[0] = value;
			REG_KEY1: key_q[1] = value;
			REG_KEY2: key_q[2] = value;
			REG_KEY3: key_q[3] = value;
			REG_NONCE_LO: nonce_lo_q = value;
			REG_NONCE_HI: nonce_hi_q = value[31:0];
			REG_INIT_CTR: ctr_init_q = value[31:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_if.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_all(logic [63:0] k0, k1, k2, k3, nl, logic [31:0] nh, ctr);
		drain();
		write_reg(REG_KEY0, k0); write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2); write_reg(REG_KEY3, k3);
		write_reg(REG_NONCE_LO, nl); write_reg(REG_NONCE_HI, {32'd0, nh});
		write_reg(REG_INIT_CTR, {32'd0, ctr});
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic send_message(int len, bit short_tail);
		for (int i = 0; i < len; i++) begin
			if (i == len - 1)
				send_item(rand64(), short_tail ? 4'($urandom_range(1, 7)) : 4'd8, 1'b1);
			else
				send_item(rand64(), 4'd8, 1'b0);
		end
	endtask

	task automatic test_directed();
		// extremes of the fields, odd byte counts and a wrapping counter
		set_all('0, '0, '0, '0, '0, '0, '0);
		send_item('0, 4'd8, 1'b0);
		send_item('1, 4'd8, 1'b0);
		send_item('1, 4'd0, 1'b0);
		send_item('1, 4'd15, 1'b0);
		send_item(64'h0123456789abcdef, 4'd3, 1'b0);
		send_item('1, 4'd1, 1'b1);
		set_all('1, '1, '1, '1, '1, 32'hffffffff, 32'hffffffff);
		for (int i = 0; i < 17; i++) send_item('1, 4'd8, i == 16);
		send_item('0, 4'd7, 1'b1);
	endtask

	task automatic test_random_messages(int items_goal);
		int start_cnt;
		start_cnt = sent;
		while (sent - start_cnt < items_goal) begin
			if ($urandom_range(0, 9) == 0)
				send_item(rand64(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
			else
				send_message($urandom_range(1, 20), 1'($urandom_range(0, 1)));
		end
		send_item(rand64(), 4'd8, 1'b1);
	endtask

	task automatic test_settings();
		for (int p = 0; p < 4; p++) begin
			set_all(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom(),
				(p == 0) ? 32'hfffffffe : $urandom());
			test_random_messages(260);
		end
	endtask

	// ready side with random stalls
	initial begin
		@(posedge arst_n);
		forever begin
			out_if.ready <= 1'b1;
			@(posedge clk);
			if (!no_idle && $urandom_range(0, 5) == 0) begin
				out_if.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready) begin
			cipher_item_t want;
			if (expected_q.size() == 0) begin
				report("unexpected result", out_if.data, '0);
			end else begin
				want = expected_q.pop_front();
				if (out_if.data !== want.data) report("data", out_if.data, want.data);
				if (out_if.count !== want.count) report("count", out_if.count, want.count);
				if (out_if.last !== want.last) report("last", out_if.last, want.last);
			end
			received++;
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings();
		no_idle = 1'b1;
		test_random_messages(60);
		drain();
		$display("sent %0d items in %0d messages, checked %0d results", sent, messages,
			received);
		$display("covered all-zero and all-one keys, counter wrap and random settings");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
